/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the GPIO expander checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define IGX_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("GPIO expander assertion failed");

// An implication checked at every clock edge outside reset.
`define IGX_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("GPIO expander assertion failed");

`endif

/* rtl/core/igx_pkg.sv */
// ----------------------------------------------------------------------------
// igx_pkg
// Types, register map and operation codes of the I2C GPIO expander block.
// ----------------------------------------------------------------------------
package igx_pkg;

    localparam int unsigned REGISTER_COUNT = 32;
    localparam int unsigned IDX_W          = $clog2(REGISTER_COUNT);
    localparam int unsigned PTR_W          = 8;
    localparam int unsigned COUNT_W        = 9;
    localparam int unsigned POS_W          = COUNT_W + 1;
    localparam int unsigned OP_W           = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register map.
    localparam int unsigned ADDR_DIR_A  = 'h00;
    localparam int unsigned ADDR_DIR_B  = 'h01;
    localparam int unsigned ADDR_PU_A   = 'h0C;
    localparam int unsigned ADDR_PU_B   = 'h0D;
    localparam int unsigned ADDR_DATA_A = 'h12;
    localparam int unsigned ADDR_DATA_B = 'h13;

    localparam logic [7:0] DIR_RESET   = 8'hFF;
    localparam logic [7:0] OTHER_RESET = 8'h00;

    // Bus event codes.
    localparam logic [OP_W-1:0] OP_ADDR_MATCH = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
    localparam logic [OP_W-1:0] OP_READ       = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [7:0]      write_byte;
        logic [7:0]      pins_in_a;
        logic [7:0]      pins_in_b;
    } igx_req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [7:0] port_a_level;
        logic [7:0] port_a_drive;
        logic [7:0] port_a_pullup;
        logic [7:0] port_b_level;
        logic [7:0] port_b_drive;
        logic [7:0] port_b_pullup;
    } igx_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } igx_cmd_t;

endpackage

/* rtl/core/igx_ctrl.sv */
// ----------------------------------------------------------------------------
// igx_ctrl
// Controller: takes a request, runs its execute state, then strobes the result.
// ----------------------------------------------------------------------------
module igx_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output igx_pkg::igx_cmd_t cmd
);
    import igx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_next   = (state_reg == ST_EXEC);
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign cmd.capture = start && (state_reg == ST_IDLE);
    assign cmd.execute = (state_reg == ST_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* rtl/core/igx_datapath.sv */
// ----------------------------------------------------------------------------
// igx_datapath
// Register file, transfer pointer and latched pad controls of the expander.
// ----------------------------------------------------------------------------
module igx_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  igx_pkg::igx_cmd_t cmd,
    input  igx_pkg::igx_req_t request,
    output igx_pkg::igx_rsp_t result
);
    import igx_pkg::*;

    igx_req_t            req_reg;
    logic [7:0]          rf_reg [REGISTER_COUNT];

    logic [PTR_W-1:0]    ptr_reg,      ptr_next;
    logic [COUNT_W-1:0]  count_reg,    count_next;
    logic                awaiting_reg, awaiting_next;
    logic                seen_reg,     seen_next;
    logic [7:0]          last_reg,     last_next;
    logic [7:0]          read_byte_reg, read_byte_next;
    logic [7:0]          lvl_a_reg, lvl_a_next, drv_a_reg, drv_a_next, pu_a_reg, pu_a_next;
    logic [7:0]          lvl_b_reg, lvl_b_next, drv_b_reg, drv_b_next, pu_b_reg, pu_b_next;

    logic [POS_W-1:0]    pos;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    logic [COUNT_W-1:0]  count_inc;
    logic                wr_en;
    logic                tick_en;
    logic [7:0]          dir_a, dir_b, data_a_new, data_b_new;

    assign pos       = POS_W'(ptr_reg) + POS_W'(count_reg);
    assign in_range  = (pos < POS_W'(REGISTER_COUNT));
    assign idx       = pos[IDX_W-1:0];
    assign count_inc = (count_reg != COUNT_MAX) ? (count_reg + 1'b1) : count_reg;

    assign dir_a      = rf_reg[IDX_W'(ADDR_DIR_A)];
    assign dir_b      = rf_reg[IDX_W'(ADDR_DIR_B)];
    assign data_a_new = (rf_reg[IDX_W'(ADDR_DATA_A)] & ~dir_a) | (req_reg.pins_in_a & dir_a);
    assign data_b_new = (rf_reg[IDX_W'(ADDR_DATA_B)] & ~dir_b) | (req_reg.pins_in_b & dir_b);

    always_comb
    begin
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        awaiting_next  = awaiting_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;
        read_byte_next = 8'h00;
        lvl_a_next     = lvl_a_reg;
        drv_a_next     = drv_a_reg;
        pu_a_next      = pu_a_reg;
        lvl_b_next     = lvl_b_reg;
        drv_b_next     = drv_b_reg;
        pu_b_next      = pu_b_reg;
        wr_en          = 1'b0;
        tick_en        = 1'b0;
        case (req_reg.operation)
            OP_ADDR_MATCH:
            begin
                awaiting_next = 1'b1;
                seen_next     = 1'b0;
                ptr_next      = '0;
                count_next    = '0;
            end
            OP_WRITE:
            begin
                last_next = req_reg.write_byte;
                if (awaiting_reg)
                begin
                    ptr_next      = req_reg.write_byte;
                    count_next    = '0;
                    awaiting_next = 1'b0;
                    seen_next     = 1'b1;
                end
                else if (in_range)
                begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                end
            end
            OP_READ:
            begin
                if (awaiting_reg)
                begin
                    ptr_next      = last_reg;
                    count_next    = '0;
                    awaiting_next = 1'b0;
                    seen_next     = 1'b1;
                end
                else
                begin
                    read_byte_next = in_range ? rf_reg[idx] : 8'h00;
                    count_next     = count_inc;
                end
            end
            OP_STOP:
            begin
                if (seen_reg)
                begin
                    lvl_a_next = rf_reg[IDX_W'(ADDR_DATA_A)] & ~dir_a;
                    drv_a_next = ~dir_a;
                    pu_a_next  = dir_a & rf_reg[IDX_W'(ADDR_PU_A)];
                    lvl_b_next = rf_reg[IDX_W'(ADDR_DATA_B)] & ~dir_b;
                    drv_b_next = ~dir_b;
                    pu_b_next  = dir_b & rf_reg[IDX_W'(ADDR_PU_B)];
                end
            end
            OP_TICK:
            begin
                tick_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.execute)
        begin
            read_byte_reg <= read_byte_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= (i == ADDR_DIR_A || i == ADDR_DIR_B) ? DIR_RESET : OTHER_RESET;
            end
        end
        else if (cmd.execute)
        begin
            if (wr_en)
            begin
                rf_reg[idx] <= req_reg.write_byte;
            end
            if (tick_en)
            begin
                rf_reg[IDX_W'(ADDR_DATA_A)] <= data_a_new;
                rf_reg[IDX_W'(ADDR_DATA_B)] <= data_b_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            count_reg    <= '0;
            awaiting_reg <= 1'b1;
            seen_reg     <= 1'b0;
            last_reg     <= 8'h00;
            lvl_a_reg    <= 8'h00;
            drv_a_reg    <= 8'h00;
            pu_a_reg     <= 8'h00;
            lvl_b_reg    <= 8'h00;
            drv_b_reg    <= 8'h00;
            pu_b_reg     <= 8'h00;
        end
        else if (cmd.execute)
        begin
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            awaiting_reg <= awaiting_next;
            seen_reg     <= seen_next;
            last_reg     <= last_next;
            lvl_a_reg    <= lvl_a_next;
            drv_a_reg    <= drv_a_next;
            pu_a_reg     <= pu_a_next;
            lvl_b_reg    <= lvl_b_next;
            drv_b_reg    <= drv_b_next;
            pu_b_reg     <= pu_b_next;
        end
    end

    assign result.read_byte     = read_byte_reg;
    assign result.port_a_level  = lvl_a_reg;
    assign result.port_a_drive  = drv_a_reg;
    assign result.port_a_pullup = pu_a_reg;
    assign result.port_b_level  = lvl_b_reg;
    assign result.port_b_drive  = drv_b_reg;
    assign result.port_b_pullup = pu_b_reg;

endmodule

/* rtl/core/i2c_gpio_expander_registers.sv */
// ----------------------------------------------------------------------------
// i2c_gpio_expander_registers
// Flow: a request is captured when taken, then executed in the execute state, and its result
// is strobed on done from a register; a new request waits until the execute state is over.
// Busy is high only in the execute cycle; a new request may be taken while done shows.
// Reset: asynchronous, active low; direction words read 0xFF, the other registers and pad latches are zero.
// ----------------------------------------------------------------------------
module i2c_gpio_expander_registers (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  igx_pkg::igx_req_t request,
    output logic              done,
    output igx_pkg::igx_rsp_t result
);
    import igx_pkg::*;

    // The controller sequences each request through a capture cycle, in which
    // the bus event is registered, and an execute cycle, in which the register
    // file, the transfer pointer and the latched pad controls are updated.
    igx_cmd_t cmd;

    igx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds all of the architectural state. Its result fields are
    // registered, so they are stable for the whole cycle in which done is high;
    // the receiver cannot hold a result off, so no output buffering is needed.
    igx_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

/* rtl/core/igx_checker.sv */
// ----------------------------------------------------------------------------
// igx_checker
// Port-level checks of the GPIO expander's request and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module igx_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input igx_pkg::igx_req_t request,
    input logic              done,
    input igx_pkg::igx_rsp_t result
);
    import igx_pkg::*;

    `IGX_ASSERT_IMPLIES(a_busy_after_take, clk, rst_n, start && !busy, ##1 busy)
    `IGX_ASSERT_IMPLIES(a_done_latency, clk, rst_n, start && !busy, ##2 done)
    `IGX_ASSERT_IMPLIES(a_done_single, clk, rst_n, done, !busy ##1 !done)
    `IGX_ASSERT_IMPLIES(a_read_zero, clk, rst_n, done && ($past(request.operation, 2) != OP_READ), result.read_byte == 8'h00)
    `IGX_ASSERT_ALWAYS(a_pullup_on_inputs, clk, rst_n, ((result.port_a_drive & result.port_a_pullup) == 8'h00) && ((result.port_b_drive & result.port_b_pullup) == 8'h00))

endmodule

bind i2c_gpio_expander_registers igx_checker u_igx_checker (.*);

/* test/tb_i2c_gpio_expander_registers.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_gpio_expander_registers
// Drives bus events into the GPIO expander register block and checks every
// response against a cycle-free shadow of the register file and pad latches,
// first with a short directed table, then with random bus transactions
// under several patterns of sender idling.
// ----------------------------------------------------------------------------
module tb_i2c_gpio_expander_registers;

    import igx_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    igx_req_t request;
    logic     done;
    igx_rsp_t result;

    i2c_gpio_expander_registers dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the expander. It is advanced once for every request
    // that the block accepts, in the order of acceptance.
    // ------------------------------------------------------------------------
    logic [7:0]         shadow_regs [REGISTER_COUNT];
    logic [PTR_W-1:0]   shadow_ptr;
    logic [COUNT_W-1:0] shadow_count;
    bit                 shadow_awaiting;
    bit                 shadow_write_seen;
    logic [7:0]         shadow_last_rx;
    igx_rsp_t           shadow_pads;

    // Responses still owed by the block, oldest first.
    igx_rsp_t pending_responses [$];

    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned idle_pct;

    // Directed table: one row per request; a row may carry a response that
    // is obvious from the reset state, which then replaces the prediction.
    typedef struct {
        igx_req_t req;
        bit       typed;
        igx_rsp_t want;
    } directed_row_t;

    directed_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run; a correct run finishes in a small fraction of it.
    initial
    begin
        #2_000_000;
        $display("FAIL i2c_gpio_expander_registers");
        $finish;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < REGISTER_COUNT; i++)
        begin
            shadow_regs[i] = OTHER_RESET;
        end
        shadow_regs[ADDR_DIR_A] = DIR_RESET;
        shadow_regs[ADDR_DIR_B] = DIR_RESET;
        shadow_ptr        = '0;
        shadow_count      = '0;
        shadow_awaiting   = 1'b1;
        shadow_write_seen = 1'b0;
        shadow_last_rx    = '0;
        shadow_pads       = '0;
    endfunction

    // The first byte of a transaction, or the first read, fixes the pointer.
    function automatic void latch_pointer(logic [7:0] ptr);
        shadow_ptr        = ptr;
        shadow_count      = '0;
        shadow_awaiting   = 1'b0;
        shadow_write_seen = 1'b1;
    endfunction

    // Applies one bus event to the shadow and returns the response it gives.
    function automatic igx_rsp_t expander_step(igx_req_t r);
        igx_rsp_t         rsp;
        logic [7:0]       rd;
        logic [POS_W-1:0] pos;
        logic [7:0]       da;
        logic [7:0]       db;

        rd  = '0;
        pos = POS_W'(shadow_ptr) + POS_W'(shadow_count);
        da  = shadow_regs[ADDR_DIR_A];
        db  = shadow_regs[ADDR_DIR_B];
        case (r.operation)
            OP_ADDR_MATCH:
            begin
                shadow_awaiting   = 1'b1;
                shadow_write_seen = 1'b0;
                shadow_ptr        = '0;
                shadow_count      = '0;
            end
            OP_WRITE:
            begin
                shadow_last_rx = r.write_byte;
                if (shadow_awaiting)
                begin
                    latch_pointer(r.write_byte);
                end
                else if (pos < REGISTER_COUNT)
                begin
                    shadow_regs[pos[IDX_W-1:0]] = r.write_byte;
                    if (shadow_count != COUNT_MAX)
                    begin
                        shadow_count++;
                    end
                end
            end
            OP_READ:
            begin
                if (shadow_awaiting)
                begin
                    latch_pointer(shadow_last_rx);
                end
                else
                begin
                    if (pos < REGISTER_COUNT)
                    begin
                        rd = shadow_regs[pos[IDX_W-1:0]];
                    end
                    if (shadow_count != COUNT_MAX)
                    begin
                        shadow_count++;
                    end
                end
            end
            OP_STOP:
            begin
                if (shadow_write_seen)
                begin
                    shadow_pads.port_a_level  = shadow_regs[ADDR_DATA_A] & ~da;
                    shadow_pads.port_a_drive  = ~da;
                    shadow_pads.port_a_pullup = da & shadow_regs[ADDR_PU_A];
                    shadow_pads.port_b_level  = shadow_regs[ADDR_DATA_B] & ~db;
                    shadow_pads.port_b_drive  = ~db;
                    shadow_pads.port_b_pullup = db & shadow_regs[ADDR_PU_B];
                end
            end
            OP_TICK:
            begin
                shadow_regs[ADDR_DATA_A] = (shadow_regs[ADDR_DATA_A] & ~da) | (r.pins_in_a & da);
                shadow_regs[ADDR_DATA_B] = (shadow_regs[ADDR_DATA_B] & ~db) | (r.pins_in_b & db);
            end
            default:
            begin
            end
        endcase
        rsp           = shadow_pads;
        rsp.read_byte = rd;
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch on %s at %0t: expected %02h, got %02h",
                         name, $realtime, want, got);
            end
        end
    endfunction

    // Every strobed response is matched against the oldest one owed.
    always @(posedge clk)
    begin
        igx_rsp_t want;

        if (rst_n && done === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("response at %0t with none outstanding: %h",
                             $realtime, result);
                end
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("read_byte",     want.read_byte,     result.read_byte);
                check_field("port_a_level",  want.port_a_level,  result.port_a_level);
                check_field("port_a_drive",  want.port_a_drive,  result.port_a_drive);
                check_field("port_a_pullup", want.port_a_pullup, result.port_a_pullup);
                check_field("port_b_level",  want.port_b_level,  result.port_b_level);
                check_field("port_b_drive",  want.port_b_drive,  result.port_b_drive);
                check_field("port_b_pullup", want.port_b_pullup, result.port_b_pullup);
            end
        end
    end

    // Presents one request, with a random idle gap before it when the current
    // phase asks for one, and waits until the block takes it. Start is left
    // high afterwards so that back-to-back requests need no extra edge.
    task automatic send_request(igx_req_t r, bit typed = 1'b0, igx_rsp_t want = '0);
        int unsigned gap;
        igx_rsp_t    predicted;

        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        // Accepted at this edge: advance the shadow in acceptance order.
        predicted = expander_step(r);
        pending_responses.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Builds a request with random pin levels, so that pin bits are exercised
    // on every kind of event and not only on sample ticks.
    function automatic igx_req_t make_request(logic [OP_W-1:0] op, logic [7:0] wb);
        igx_req_t r;

        r.operation  = op;
        r.write_byte = wb;
        r.pins_in_a  = 8'($urandom);
        r.pins_in_b  = 8'($urandom);
        return r;
    endfunction

    // Lets the block deliver everything it owes before going on.
    task automatic drain_responses();
        start <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void add_row(logic [OP_W-1:0] op, logic [7:0] wb,
                                    logic [7:0] pa, logic [7:0] pb,
                                    bit typed = 1'b0, igx_rsp_t want = '0);
        directed_row_t row;

        row.req.operation  = op;
        row.req.write_byte = wb;
        row.req.pins_in_a  = pa;
        row.req.pins_in_b  = pb;
        row.typed          = typed;
        row.want           = want;
        directed_rows.push_back(row);
    endfunction

    // Picks a register pointer, mostly at the mapped registers or elsewhere
    // inside the file, sometimes anywhere in the byte range.
    function automatic logic [7:0] pick_pointer();
        case ($urandom_range(9))
            0: return 8'(ADDR_DIR_A);
            1: return 8'(ADDR_DIR_B);
            2: return 8'(ADDR_PU_A);
            3: return 8'(ADDR_PU_B);
            4: return 8'(ADDR_DATA_A);
            5: return 8'(ADDR_DATA_B);
            6, 7: return 8'($urandom_range(REGISTER_COUNT - 1));
            default: return 8'($urandom);
        endcase
    endfunction

    // One random bus transaction. Most are well formed, so that written
    // registers reach the pads and reads walk the file; the rest are ticks
    // and stray events of any code, including the unused ones.
    task automatic random_transaction();
        int unsigned kind;
        int unsigned n;

        kind = $urandom_range(99);
        if (kind < 40)
        begin
            send_request(make_request(OP_ADDR_MATCH, 8'($urandom)));
            send_request(make_request(OP_WRITE, pick_pointer()));
            n = $urandom_range(1, 6);
            repeat (n) send_request(make_request(OP_WRITE, 8'($urandom)));
            if ($urandom_range(9) != 0)
            begin
                send_request(make_request(OP_STOP, 8'($urandom)));
            end
        end
        else if (kind < 65)
        begin
            send_request(make_request(OP_ADDR_MATCH, 8'($urandom)));
            if ($urandom_range(9) < 7)
            begin
                send_request(make_request(OP_WRITE, pick_pointer()));
                // Repeated start before the read phase, as a real master does.
                if ($urandom_range(1) != 0)
                begin
                    send_request(make_request(OP_ADDR_MATCH, 8'($urandom)));
                end
            end
            n = $urandom_range(1, 6);
            repeat (n) send_request(make_request(OP_READ, 8'($urandom)));
            send_request(make_request(OP_STOP, 8'($urandom)));
        end
        else if (kind < 80)
        begin
            send_request(make_request(OP_TICK, 8'($urandom)));
        end
        else
        begin
            send_request(make_request(OP_W'($urandom_range(7)), 8'($urandom)));
        end
    endtask

    initial
    begin
        int unsigned phase_pct [4];

        phase_pct[0] = 0;
        phase_pct[1] = 49;
        phase_pct[2] = 0;
        phase_pct[3] = 35;

        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        mismatches    = 0;
        requests_sent = 0;
        idle_pct      = 0;
        clear_shadow();

        // --------------------------------------------------------------------
        // Directed table.
        // --------------------------------------------------------------------
        // A read straight after reset takes its pointer from the last byte
        // received, which is still zero, and transmits nothing.
        add_row(OP_READ,       8'h00, 8'h00, 8'h00, 1'b1, '0);
        add_row(OP_ADDR_MATCH, 8'h00, 8'h00, 8'h00, 1'b1, '0);
        // First byte of the transaction sets the pointer to the direction words.
        add_row(OP_WRITE,      8'h00, 8'hFF, 8'hFF, 1'b1, '0);
        add_row(OP_WRITE,      8'h00, 8'h00, 8'h00, 1'b1, '0);
        add_row(OP_WRITE,      8'h0F, 8'h00, 8'h00, 1'b1, '0);
        // Stop re-latches the pads: port A all driven, port B high nibble driven.
        add_row(OP_STOP,       8'h00, 8'h00, 8'h00, 1'b1,
                {8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hF0, 8'h00});
        // Data registers, then the pull-up registers.
        add_row(OP_ADDR_MATCH, 8'h00, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'(ADDR_DATA_A), 8'h00, 8'h00);
        add_row(OP_WRITE,      8'hA5, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'h5A, 8'h00, 8'h00);
        add_row(OP_ADDR_MATCH, 8'h00, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'(ADDR_PU_A), 8'h00, 8'h00);
        add_row(OP_WRITE,      8'hFF, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'hFF, 8'h00, 8'h00);
        add_row(OP_STOP,       8'h00, 8'h00, 8'h00);
        // Repeated stop re-latches again from the current registers.
        add_row(OP_STOP,       8'h00, 8'h00, 8'h00);
        // Sample tick with all pins high, then all low; only input pins follow.
        add_row(OP_TICK,       8'h00, 8'hFF, 8'hFF);
        add_row(OP_TICK,       8'h00, 8'h00, 8'h00);
        // Read back port B data within a transaction.
        add_row(OP_ADDR_MATCH, 8'h00, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'(ADDR_DATA_B), 8'h00, 8'h00);
        add_row(OP_READ,       8'h00, 8'h00, 8'h00);
        // Last register written, the next byte falls off the end and is
        // dropped, and a read from there returns zero.
        add_row(OP_ADDR_MATCH, 8'h00, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'(REGISTER_COUNT - 1), 8'h00, 8'h00);
        add_row(OP_WRITE,      8'h77, 8'h00, 8'h00);
        add_row(OP_WRITE,      8'hFF, 8'h00, 8'h00);
        add_row(OP_READ,       8'h00, 8'h00, 8'h00);
        // Stop with no first byte seen leaves the pads alone.
        add_row(OP_ADDR_MATCH, 8'h00, 8'h00, 8'h00);
        add_row(OP_STOP,       8'h00, 8'h00, 8'h00);
        // Unused event codes change nothing.
        add_row(3'd5,          8'hFF, 8'hFF, 8'hFF);
        add_row(3'd7,          8'h00, 8'h00, 8'h00);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_responses();

        // --------------------------------------------------------------------
        // Random transactions, one idling pattern per phase. Each phase ends
        // with the sender holding off until every response has come back.
        // --------------------------------------------------------------------
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = phase_pct[phase];
            if (phase == 2)
            begin
                // One long read burst, so the transfer count runs into its
                // saturation point well past the end of the file.
                send_request(make_request(OP_ADDR_MATCH, 8'($urandom)));
                send_request(make_request(OP_WRITE, 8'($urandom_range(REGISTER_COUNT - 1))));
                repeat (int'(COUNT_MAX) + 20)
                begin
                    send_request(make_request(OP_READ, 8'($urandom)));
                end
                send_request(make_request(OP_STOP, 8'($urandom)));
            end
            while (requests_sent < 30 + (phase + 1) * 160 + (phase >= 2 ? 530 : 0))
            begin
                random_transaction();
            end
            drain_responses();
        end

        // Let any stray strobe show itself before the verdict.
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_responses.size() == 0)
        begin
            $display("PASS i2c_gpio_expander_registers");
        end
        else
        begin
            $display("FAIL i2c_gpio_expander_registers");
        end
        $finish;
    end

endmodule
